/* rtl/core/tile_grid_store_engine_unit_macros.svh */
// Assertion macros shared by the tile grid store RTL.
`ifndef TILE_GRID_STORE_ENGINE_UNIT_MACROS_SVH
`define TILE_GRID_STORE_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tgse_pkg.sv */
// Package: sizes, mode codes and register indexes of the tile grid store.
`default_nettype none

package tgse_pkg;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int TILE_BITS   = 16;

    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOT_W  = $clog2(DEPTH + 1);
    localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int CNT_W  = 13;
    localparam int PADDR_W = 4;

    typedef logic signed [TILE_BITS-1:0] t_tile;
    typedef logic signed [17:0]          t_coord;

    localparam logic [3:0] MODE_READ_CELL   = 4'd0;
    localparam logic [3:0] MODE_WRITE_CELL  = 4'd1;
    localparam logic [3:0] MODE_WRITE_INDEX = 4'd2;
    localparam logic [3:0] MODE_READ_WORLD  = 4'd3;
    localparam logic [3:0] MODE_WRITE_WORLD = 4'd4;
    localparam logic [3:0] MODE_REPLACE     = 4'd5;
    localparam logic [3:0] MODE_RECT        = 4'd6;
    localparam logic [3:0] MODE_DISC        = 4'd7;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_TILE_W  = 2'd2;
    localparam logic [1:0] REG_TILE_H  = 2'd3;

endpackage

`default_nettype wire

/* rtl/core/tile_grid_store_engine_unit.sv */
// World ops run two 16-step divisions (x, then y) before the cell access.
// Replace reads every cell in use and rewrites the matching ones; rectangle writes each clipped cell.
// Disc: tests each cell of the clipped bounding box against the radius, column by column.
// One word at a time: ready only while idle; the result sits in an output register.
// Reset (synchronous, active low) starts a pass that writes -1 to every
// cell, one per cycle, while no word is taken; config writes are accepted throughout.
`default_nettype none

`include "tile_grid_store_engine_unit_macros.svh"

module tile_grid_store_engine_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tgse_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // input channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic        [3:0]             i_mode,
    input  wire logic signed [8:0]             i_cell_x,
    input  wire logic signed [8:0]             i_cell_y,
    input  wire logic        [11:0]            i_cell_index,
    input  wire logic signed [15:0]            i_world_x,
    input  wire logic signed [15:0]            i_world_y,
    input  wire logic signed [15:0]            i_tile_value,
    input  wire logic signed [15:0]            i_match_value,
    input  wire logic        [7:0]             i_fill_width,
    input  wire logic        [7:0]             i_fill_height,
    input  wire logic        [6:0]             i_disc_radius,
    // output channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [15:0]                 o_read_tile,
    output logic                               o_in_bounds,
    output logic [tgse_pkg::CNT_W-1:0]         o_cells_changed
);

    localparam int AW = tgse_pkg::ADDR_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLEAR = 4'd1;
    localparam logic [3:0] ST_DIV   = 4'd2;
    localparam logic [3:0] ST_PT    = 4'd3;
    localparam logic [3:0] ST_RDW   = 4'd4;
    localparam logic [3:0] ST_RPRD  = 4'd5;
    localparam logic [3:0] ST_RPCMP = 4'd6;
    localparam logic [3:0] ST_RECT  = 4'd7;
    localparam logic [3:0] ST_DINIT = 4'd8;
    localparam logic [3:0] ST_DSQ   = 4'd9;
    localparam logic [3:0] ST_DISC  = 4'd10;
    localparam logic [3:0] ST_FIN   = 4'd11;

    // configuration registers
    logic [6:0] r_cols_cfg, r_rows_cfg;
    logic [8:0] r_tw_cfg, r_th_cfg;

    // control
    logic [3:0]  r_state, n_state;
    logic [AW-1:0] r_i, n_i;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_divy, n_divy;
    logic        r_neg, n_neg;
    logic        r_oval, n_oval;

    // work payload
    logic [3:0]            r_mode, n_mode;
    tgse_pkg::t_coord      r_cx, n_cx, r_cy, n_cy;
    logic [11:0]           r_idx, n_idx;
    logic signed [15:0]    r_wy, n_wy;
    tgse_pkg::t_tile       r_tv, n_tv;
    logic signed [15:0]    r_mv, n_mv;
    logic [6:0]            r_rad, n_rad;
    tgse_pkg::t_coord      r_px, n_px, r_py, n_py;
    tgse_pkg::t_coord      r_x, n_x, r_y, n_y;
    tgse_pkg::t_coord      r_xe, n_xe, r_ys, n_ys, r_ye, n_ye;
    logic [15:0]           r_q, n_q;
    logic [8:0]            r_rem, n_rem;
    logic signed [17:0]    r_dx2, n_dx2, r_rad2, n_rad2;
    logic signed [15:0]    r_rd, n_rd;
    logic                  r_ok, n_ok;
    logic [tgse_pkg::CNT_W-1:0] r_chg, n_chg;
    logic signed [15:0]    r_ord, n_ord;
    logic                  r_ook, n_ook;
    logic [tgse_pkg::CNT_W-1:0] r_ochg, n_ochg;

    // memory
    logic [tgse_pkg::TILE_BITS-1:0] r_mem [0:tgse_pkg::DEPTH-1];
    logic [tgse_pkg::TILE_BITS-1:0] r_rdata;
    logic                           w_en, rd_en;
    logic [AW-1:0]                  w_addr, rd_addr;
    logic [tgse_pkg::TILE_BITS-1:0] w_data;

    // grid size in use
    logic [tgse_pkg::COL_W-1:0] cols;
    logic [tgse_pkg::ROW_W-1:0] rows;
    logic [tgse_pkg::TOT_W-1:0] total;
    tgse_pkg::t_coord           cols_s, rows_s;

    assign cols = (int'(r_cols_cfg) > tgse_pkg::MAX_COLUMNS)
                ? tgse_pkg::COL_W'(tgse_pkg::MAX_COLUMNS) : tgse_pkg::COL_W'(r_cols_cfg);
    assign rows = (int'(r_rows_cfg) > tgse_pkg::MAX_ROWS)
                ? tgse_pkg::ROW_W'(tgse_pkg::MAX_ROWS) : tgse_pkg::ROW_W'(r_rows_cfg);
    assign total  = tgse_pkg::TOT_W'(tgse_pkg::TOT_W'(cols) * tgse_pkg::TOT_W'(rows));
    assign cols_s = 18'(cols);
    assign rows_s = 18'(rows);

    function automatic logic in_grid(tgse_pkg::t_coord x, tgse_pkg::t_coord y,
                                     tgse_pkg::t_coord cs, tgse_pkg::t_coord rs);
        return (x >= 18'sd0) && (x < cs) && (y >= 18'sd0) && (y < rs);
    endfunction

    function automatic logic [AW-1:0] cell_addr(tgse_pkg::t_coord x, tgse_pkg::t_coord y,
                                                logic [tgse_pkg::COL_W-1:0] c);
        return AW'(AW'(y) * AW'(c) + AW'(x));
    endfunction

    function automatic tgse_pkg::t_coord cmin(tgse_pkg::t_coord a, tgse_pkg::t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic tgse_pkg::t_coord cmax(tgse_pkg::t_coord a, tgse_pkg::t_coord b);
        return (a > b) ? a : b;
    endfunction

    // accept-time setup values
    tgse_pkg::t_coord in_cx, in_cy, in_fw, in_fh, in_rad;
    logic             in_inside;
    assign in_cx     = 18'(i_cell_x);
    assign in_cy     = 18'(i_cell_y);
    assign in_fw     = 18'({10'd0, i_fill_width});
    assign in_fh     = 18'({10'd0, i_fill_height});
    assign in_rad    = 18'({11'd0, i_disc_radius});
    assign in_inside = in_grid(in_cx, in_cy, cols_s, rows_s);

    // shared divider step
    logic [8:0]       div_d;
    logic [9:0]       div_t;
    logic             div_ge;
    logic [8:0]       div_rem;
    logic [15:0]      div_q;
    tgse_pkg::t_coord div_qs, div_res;
    always_comb begin
        if (r_divy) begin
            div_d = (r_th_cfg == 9'd0) ? 9'd1 : r_th_cfg;
        end else begin
            div_d = (r_tw_cfg == 9'd0) ? 9'd1 : r_tw_cfg;
        end
    end
    assign div_t   = {r_rem, r_q[15]};
    assign div_ge  = div_t >= {1'b0, div_d};
    assign div_rem = div_ge ? 9'(div_t - {1'b0, div_d}) : div_t[8:0];
    assign div_q   = {r_q[14:0], div_ge};
    assign div_qs  = 18'({2'b00, div_q});
    assign div_res = r_neg ? (-div_qs - 18'(div_rem != 9'd0)) : div_qs;

    // shared squarer for the disc
    logic signed [8:0]  sq_in;
    logic signed [17:0] sq_out;
    tgse_pkg::t_coord   dx_c, dy_c;
    assign dx_c   = r_x - r_cx;
    assign dy_c   = r_y - r_cy;
    assign sq_out = sq_in * sq_in;

    always_comb begin
        unique case (r_state)
            ST_DINIT: sq_in = 9'({11'd0, r_rad});
            ST_DSQ:   sq_in = 9'(dx_c);
            default:  sq_in = 9'(dy_c);
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);
    assign pready  = 1'b1;

    always_comb begin
        n_state = r_state; n_i = r_i; n_cnt = r_cnt; n_divy = r_divy; n_neg = r_neg;
        n_oval = r_oval;
        n_mode = r_mode; n_cx = r_cx; n_cy = r_cy; n_idx = r_idx; n_wy = r_wy;
        n_tv = r_tv; n_mv = r_mv; n_rad = r_rad; n_px = r_px; n_py = r_py;
        n_x = r_x; n_y = r_y; n_xe = r_xe; n_ys = r_ys; n_ye = r_ye;
        n_q = r_q; n_rem = r_rem; n_dx2 = r_dx2; n_rad2 = r_rad2;
        n_rd = r_rd; n_ok = r_ok; n_chg = r_chg;
        n_ord = r_ord; n_ook = r_ook; n_ochg = r_ochg;
        w_en = 1'b0; w_addr = r_i; w_data = r_tv;
        rd_en = 1'b0; rd_addr = r_i;

        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                w_en   = 1'b1;
                w_data = '1;
                n_i    = r_i + 1'b1;
                if (r_i == AW'(tgse_pkg::DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_mode = i_mode; n_cx = in_cx; n_cy = in_cy; n_idx = i_cell_index;
                    n_wy = i_world_y; n_tv = tgse_pkg::t_tile'(i_tile_value);
                    n_mv = i_match_value; n_rad = i_disc_radius;
                    n_px = in_cx; n_py = in_cy;
                    n_rd = -16'sd1; n_ok = 1'b0; n_chg = '0;
                    n_state = ST_FIN;
                    unique case (i_mode) inside
                        tgse_pkg::MODE_READ_CELL, tgse_pkg::MODE_WRITE_CELL,
                        tgse_pkg::MODE_WRITE_INDEX: begin
                            n_state = ST_PT;
                        end
                        tgse_pkg::MODE_READ_WORLD, tgse_pkg::MODE_WRITE_WORLD: begin
                            n_q = 16'(-i_world_x); n_neg = i_world_x[15];
                            if (!i_world_x[15]) begin
                                n_q = i_world_x;
                            end
                            n_rem = '0; n_cnt = '0; n_divy = 1'b0;
                            n_state = ST_DIV;
                        end
                        tgse_pkg::MODE_REPLACE: begin
                            n_i = '0;
                            if (total != '0) begin
                                n_state = ST_RPRD;
                            end
                        end
                        tgse_pkg::MODE_RECT: begin
                            n_ok = in_inside;
                            n_x  = in_cx; n_y = in_cy; n_ys = in_cy;
                            n_xe = cmin(in_cx + in_fw - 18'sd1, cols_s - 18'sd1);
                            n_ye = cmin(in_cy + in_fh - 18'sd1, rows_s - 18'sd1);
                            if (in_inside && (i_fill_width != 8'd0) && (i_fill_height != 8'd0)) begin
                                n_state = ST_RECT;
                            end
                        end
                        tgse_pkg::MODE_DISC: begin
                            n_ok = in_inside;
                            n_x  = cmax(in_cx - in_rad, 18'sd0);
                            n_xe = cmin(in_cx + in_rad, cols_s - 18'sd1);
                            n_ys = cmax(in_cy - in_rad, 18'sd0);
                            n_ye = cmin(in_cy + in_rad, rows_s - 18'sd1);
                            if (in_inside) begin
                                n_state = ST_DINIT;
                            end
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                n_q = div_q; n_rem = div_rem; n_cnt = r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    if (!r_divy) begin
                        // x done: load y
                        n_px = div_res;
                        n_q = r_wy[15] ? 16'(-r_wy) : r_wy;
                        n_neg = r_wy[15]; n_rem = '0; n_cnt = '0; n_divy = 1'b1;
                    end else begin
                        n_py = div_res;
                        n_state = ST_PT;
                    end
                end
            end
            ST_PT: begin
                n_state = ST_FIN;
                unique case (r_mode) inside
                    tgse_pkg::MODE_WRITE_INDEX: begin
                        if (tgse_pkg::TOT_W'(r_idx) < total) begin
                            w_en = 1'b1; w_addr = AW'(r_idx);
                            n_ok = 1'b1; n_chg = tgse_pkg::CNT_W'(1);
                        end
                    end
                    tgse_pkg::MODE_READ_CELL, tgse_pkg::MODE_READ_WORLD: begin
                        if (in_grid(r_px, r_py, cols_s, rows_s)) begin
                            rd_en = 1'b1; rd_addr = cell_addr(r_px, r_py, cols);
                            n_ok = 1'b1; n_state = ST_RDW;
                        end
                    end
                    default: begin
                        if (in_grid(r_px, r_py, cols_s, rows_s)) begin
                            w_en = 1'b1; w_addr = cell_addr(r_px, r_py, cols);
                            n_ok = 1'b1; n_chg = tgse_pkg::CNT_W'(1);
                        end
                    end
                endcase
            end
            ST_RDW: begin
                n_rd = 16'($signed(r_rdata));
                n_state = ST_FIN;
            end
            ST_RPRD: begin
                rd_en = 1'b1;
                n_state = ST_RPCMP;
            end
            ST_RPCMP: begin
                if (33'($signed(r_rdata)) == 33'(r_mv)) begin
                    w_en = 1'b1;
                    n_chg = r_chg + 1'b1;
                end
                n_i = r_i + 1'b1;
                n_state = ST_RPRD;
                if (tgse_pkg::TOT_W'(r_i) == total - 1'b1) begin
                    n_state = ST_FIN;
                end
            end
            ST_RECT: begin
                w_en = 1'b1; w_addr = cell_addr(r_x, r_y, cols);
                n_chg = r_chg + 1'b1;
                n_y = r_y + 18'sd1;
                if (r_y == r_ye) begin
                    n_y = r_ys; n_x = r_x + 18'sd1;
                    if (r_x == r_xe) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DINIT: begin
                n_rad2 = sq_out;
                n_state = ST_DSQ;
            end
            ST_DSQ: begin
                n_dx2 = sq_out;
                n_y = r_ys;
                n_state = ST_DISC;
            end
            ST_DISC: begin
                if (r_dx2 + sq_out <= r_rad2) begin
                    w_en = 1'b1; w_addr = cell_addr(r_x, r_y, cols);
                    n_chg = r_chg + 1'b1;
                end
                n_y = r_y + 18'sd1;
                if (r_y == r_ye) begin
                    n_x = r_x + 18'sd1;
                    n_state = (r_x == r_xe) ? ST_FIN : ST_DSQ;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (!r_oval || i_ready) begin
                    n_oval = 1'b1;
                    n_ord = r_rd; n_ook = r_ok; n_ochg = r_chg;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_i     <= '0;
            r_cnt   <= '0;
            r_divy  <= 1'b0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_cnt   <= n_cnt;
            r_divy  <= n_divy;
            r_oval  <= n_oval;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= 7'd64;
            r_rows_cfg <= 7'd64;
            r_tw_cfg   <= 9'd16;
            r_th_cfg   <= 9'd16;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                tgse_pkg::REG_COLUMNS: r_cols_cfg <= pwdata[6:0];
                tgse_pkg::REG_ROWS:    r_rows_cfg <= pwdata[6:0];
                tgse_pkg::REG_TILE_W:  r_tw_cfg   <= pwdata[8:0];
                tgse_pkg::REG_TILE_H:  r_th_cfg   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tgse_pkg::REG_COLUMNS: prdata = {25'd0, r_cols_cfg};
            tgse_pkg::REG_ROWS:    prdata = {25'd0, r_rows_cfg};
            tgse_pkg::REG_TILE_W:  prdata = {23'd0, r_tw_cfg};
            tgse_pkg::REG_TILE_H:  prdata = {23'd0, r_th_cfg};
            default:               prdata = '0;
        endcase
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_neg <= n_neg;
        r_mode <= n_mode; r_cx <= n_cx; r_cy <= n_cy; r_idx <= n_idx; r_wy <= n_wy;
        r_tv <= n_tv; r_mv <= n_mv; r_rad <= n_rad; r_px <= n_px; r_py <= n_py;
        r_x <= n_x; r_y <= n_y; r_xe <= n_xe; r_ys <= n_ys; r_ye <= n_ye;
        r_q <= n_q; r_rem <= n_rem; r_dx2 <= n_dx2; r_rad2 <= n_rad2;
        r_rd <= n_rd; r_ok <= n_ok; r_chg <= n_chg;
        r_ord <= n_ord; r_ook <= n_ook; r_ochg <= n_ochg;
    end

    // tile store
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_valid         = r_oval;
    assign o_read_tile     = r_ord;
    assign o_in_bounds     = r_ook;
    assign o_cells_changed = r_ochg;

    `TGS_ASSERT_NOW(a_oob_reads_empty, o_valid && !o_in_bounds, o_read_tile == -16'sd1, "out-of-bounds result with a tile value")
    `TGS_ASSERT_NOW(a_no_accept_clear, r_state == ST_CLEAR, !o_ready, "word accepted during clearing pass")
    `TGS_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "ready right after accept")
    `TGS_ASSERT_NOW(a_replace_in_range, r_state == ST_RPCMP, tgse_pkg::TOT_W'(r_i) < total, "replace sweep past grid")

endmodule

`default_nettype wire
